// File: design/lpht_pkg.sv
// lpht_pkg: shared widths, request modes and result status codes for the
// linear probe hash table; no dependencies
package lpht_pkg;

  localparam int unsigned KEY_W              = 32;
  localparam int unsigned VALUE_W            = 16;
  localparam int unsigned MODE_W             = 2;
  localparam int unsigned STATUS_W           = 2;
  localparam int unsigned SLOT_W             = 4;
  localparam int unsigned DEFAULT_SLOT_COUNT = 16;

  localparam logic [MODE_W-1:0] MODE_PROBE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PROBE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CHAIN_INSERT = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd2;

  typedef struct packed {
    logic start;
    logic done;
  } mod_ctrl_t;

endpackage

// File: design/lpht_req_if.sv
// lpht_req_if: valid/ready request channel carrying mode, key and value
// depends on lpht_pkg
interface lpht_req_if
  import lpht_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [KEY_W-1:0]   key;
  logic [VALUE_W-1:0] value;

  modport source (output valid, mode, key, value, input ready);
  modport sink   (input valid, mode, key, value, output ready);
endinterface

// File: design/lpht_rsp_if.sv
// lpht_rsp_if: valid/ready result channel carrying status and slot
// depends on lpht_pkg
interface lpht_rsp_if
  import lpht_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;

  modport source (output valid, status, slot, input ready);
  modport sink   (input valid, status, slot, output ready);
endinterface

// File: design/lpht_mod.sv
// lpht_mod: remainder of a key by the slot count through a reciprocal multiply
// done is registered from start and rises in the cycle after it; depends on lpht_pkg
module lpht_mod
  import lpht_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = DEFAULT_SLOT_COUNT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mod_ctrl_t                     ctrl_i,
  input  logic [KEY_W-1:0]              key_i,
  output mod_ctrl_t                     ctrl_o,
  output logic [$clog2(SLOT_COUNT)-1:0] rem_o
);
  localparam int unsigned IW      = $clog2(SLOT_COUNT);
  localparam int unsigned RECIP_W = KEY_W + 1;
  localparam int unsigned PROD_W  = KEY_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << (KEY_W + IW)) + 64'(SLOT_COUNT) - 64'd1) / 64'(SLOT_COUNT));
  localparam logic [IW-1:0] DIVISOR = IW'(SLOT_COUNT);

  logic              busy_q;
  logic [IW-1:0]     quot_q, quot_d;
  logic [IW-1:0]     key_lo_q, key_lo_d;
  logic [PROD_W-1:0] prod;
  logic [2*IW-1:0]   back;

  // low bits of the quotient are enough, the remainder is below 2**IW
  assign prod     = PROD_W'(key_i) * PROD_W'(RECIP);
  assign quot_d   = ctrl_i.start ? prod[KEY_W+IW +: IW] : quot_q;
  assign key_lo_d = ctrl_i.start ? key_i[IW-1:0] : key_lo_q;
  assign back     = {{IW{1'b0}}, quot_q} * {{IW{1'b0}}, DIVISOR};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= ctrl_i.start;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q   <= quot_d;
    key_lo_q <= key_lo_d;
  end

  assign ctrl_o.start = busy_q;
  assign ctrl_o.done  = busy_q;
  assign rem_o        = key_lo_q - back[IW-1:0];

endmodule

// File: design/linear_probe_hash_table.sv
// linear_probe_hash_table: open-addressing hash table with linear probing and chaining
// steps: key remainder (skipped for a power-of-two slot count), a probe of at most
// SLOT_COUNT slots, a chain walk of at most SLOT_COUNT links for chained insert, then the result register
// one item at a time: no new request is taken until the result has been accepted
// reset: a clearing pass over all SLOT_COUNT slots empties the table before the first item
// depends on lpht_pkg, lpht_req_if, lpht_rsp_if, lpht_mod
module linear_probe_hash_table
  import lpht_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = DEFAULT_SLOT_COUNT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lpht_req_if.sink   req_i,
  lpht_rsp_if.source rsp_o
);
  localparam int unsigned IW = $clog2(SLOT_COUNT);
  localparam logic [IW-1:0] SLOT_LAST = IW'(SLOT_COUNT - 1);
  localparam bit IS_POW2 = ((SLOT_COUNT & (SLOT_COUNT - 1)) == 0);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MOD   = 3'd2;
  localparam logic [2:0] ST_PROBE = 3'd3;
  localparam logic [2:0] ST_CHAIN = 3'd4;
  localparam logic [2:0] ST_RESP  = 3'd5;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic               used;
    logic               deleted;
    logic               link_null;
    logic [IW-1:0]      link;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{key: '0, value: '0, used: 1'b0, deleted: 1'b0,
                                     link_null: 1'b1, link: '0};

  entry_t mem [SLOT_COUNT];
  entry_t rd_q;
  entry_t wr_data;
  logic   we;

  logic [2:0]          state_q, state_d;
  logic [IW-1:0]       ptr_q, ptr_d;
  logic [IW-1:0]       home_q, home_d;
  logic [IW-1:0]       new_q, new_d;
  logic [IW-1:0]       n_q, n_d;
  logic [MODE_W-1:0]   mode_q, mode_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [VALUE_W-1:0]  value_q, value_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;

  logic [IW-1:0]        ptr_next;
  logic [IW+SLOT_W-1:0] ptr_wide;
  logic [IW+SLOT_W-1:0] new_wide;
  logic                 accept;
  mod_ctrl_t            mod_in, mod_out;
  logic [IW-1:0]        mod_rem;

  lpht_mod #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mod_in),
    .key_i  (req_i.key),
    .ctrl_o (mod_out),
    .rem_o  (mod_rem)
  );

  assign accept   = req_i.valid && req_i.ready;
  assign ptr_next = (ptr_q == SLOT_LAST) ? '0 : ptr_q + 1'b1;
  assign ptr_wide = {{SLOT_W{1'b0}}, ptr_q};
  assign new_wide = {{SLOT_W{1'b0}}, new_q};

  assign req_i.ready  = (state_q == ST_IDLE);
  assign rsp_o.valid  = (state_q == ST_RESP);
  assign rsp_o.status = status_q;
  assign rsp_o.slot   = slot_q;

  always_comb begin
    state_d  = state_q;
    ptr_d    = ptr_q;
    home_d   = home_q;
    new_d    = new_q;
    n_d      = n_q;
    mode_d   = mode_q;
    key_d    = key_q;
    value_d  = value_q;
    status_d = status_q;
    slot_d   = slot_q;
    we       = 1'b0;
    wr_data  = rd_q;
    mod_in.start = 1'b0;
    mod_in.done  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        we      = 1'b1;
        wr_data = ENTRY_RESET;
        ptr_d   = ptr_next;
        if (ptr_q == SLOT_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          mode_d  = req_i.mode;
          key_d   = req_i.key;
          value_d = req_i.value;
          n_d     = '0;
          if (req_i.mode != MODE_PROBE_INSERT && req_i.mode != MODE_PROBE_DELETE &&
              req_i.mode != MODE_CHAIN_INSERT) begin
            status_d = STATUS_MISSING;
            slot_d   = '0;
            state_d  = ST_RESP;
          end else if (IS_POW2) begin
            ptr_d   = req_i.key[IW-1:0];
            home_d  = req_i.key[IW-1:0];
            state_d = ST_PROBE;
          end else begin
            mod_in.start = 1'b1;
            state_d      = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        if (mod_out.done) begin
          ptr_d   = mod_rem;
          home_d  = mod_rem;
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: begin
        priority if (mode_q == MODE_PROBE_INSERT && (!rd_q.used || rd_q.deleted)) begin
          we       = 1'b1;
          wr_data  = '{key: key_q, value: value_q, used: 1'b1, deleted: 1'b0,
                       link_null: 1'b1, link: '0};
          status_d = STATUS_DONE;
          slot_d   = ptr_wide[SLOT_W-1:0];
          state_d  = ST_RESP;
        end else if (mode_q == MODE_PROBE_DELETE && rd_q.used && !rd_q.deleted &&
                     rd_q.key == key_q) begin
          we              = 1'b1;
          wr_data.deleted = 1'b1;
          status_d        = STATUS_DONE;
          slot_d          = ptr_wide[SLOT_W-1:0];
          state_d         = ST_RESP;
        end else if (mode_q == MODE_CHAIN_INSERT && !rd_q.used) begin
          we            = 1'b1;
          wr_data.key   = key_q;
          wr_data.value = value_q;
          wr_data.used  = 1'b1;
          new_d         = ptr_q;
          ptr_d         = home_q;
          n_d           = '0;
          state_d       = ST_CHAIN;
        end else if (n_q == SLOT_LAST) begin
          status_d = (mode_q == MODE_PROBE_DELETE) ? STATUS_MISSING : STATUS_FULL;
          slot_d   = '0;
          state_d  = ST_RESP;
        end else begin
          ptr_d = ptr_next;
          n_d   = n_q + 1'b1;
        end
      end
      ST_CHAIN: begin
        priority if (rd_q.link_null) begin
          if (ptr_q != new_q) begin
            we                = 1'b1;
            wr_data.link_null = 1'b0;
            wr_data.link      = new_q;
          end
          status_d = STATUS_DONE;
          slot_d   = new_wide[SLOT_W-1:0];
          state_d  = ST_RESP;
        end else if (n_q == SLOT_LAST) begin
          status_d = STATUS_DONE;
          slot_d   = new_wide[SLOT_W-1:0];
          state_d  = ST_RESP;
        end else begin
          ptr_d = rd_q.link;
          n_d   = n_q + 1'b1;
        end
      end
      ST_RESP: begin
        if (rsp_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      ptr_q   <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      n_q     <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    home_q   <= home_d;
    new_q    <= new_d;
    mode_q   <= mode_d;
    key_q    <= key_d;
    value_q  <= value_d;
    status_q <= status_d;
    slot_q   <= slot_d;
  end

  // slot memory: one write port, one registered read port at the next pointer
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[ptr_q] <= wr_data;
    end
    rd_q <= mem[ptr_d];
  end

endmodule

// File: design/lpht_checker.sv
// lpht_checker: port-level checks of the hash table handshakes over time
// depends on lpht_pkg; bound to linear_probe_hash_table
module lpht_checker
  import lpht_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_ready_i,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic [STATUS_W-1:0] rsp_status_i,
  input logic [SLOT_W-1:0]   rsp_slot_i
);

  // ready drops in the cycle after an item is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("ready right after accept");

  // no new item while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !req_ready_i)
    else $error("ready while result pending");

  // failed requests report slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != STATUS_DONE |-> rsp_slot_i == '0)
    else $error("nonzero slot on failure");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_status_i == STATUS_DONE || rsp_status_i == STATUS_FULL ||
                     rsp_status_i == STATUS_MISSING))
    else $error("bad status code");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i) &&
                                     $stable(rsp_slot_i))
    else $error("stalled result changed");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_slot_i   (rsp_o.slot)
);
